// ===== rtl/core/espi_pkg.sv =====
// Shared constants, codes and types for the encoder speed PI controller.
// No dependencies; every other file of the block imports this package.
package espi_pkg;

   // Window and counter sizing
   localparam int WINDOW_LEN = 5;
   localparam int COUNT_BITS = 32;
   localparam int SPEED_W    = 32;
   localparam int IDX_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int FILL_W     = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W      = SPEED_W + $clog2(WINDOW_LEN);

   // Divider: magnitude of window_sum scaled by 256
   localparam int DVD_W  = SUM_W + 8;
   localparam int STEP_W = $clog2(DVD_W);

   // Multiplier: 24 x 24 partial products over a 48-bit operand
   localparam int GAIN_W  = 24;
   localparam int CHUNK_W = 24;
   localparam int OPA_W   = 2 * CHUNK_W;
   localparam int PROD_W  = CHUNK_W + GAIN_W;
   localparam int ACC_W   = OPA_W + GAIN_W;

   // PI arithmetic widths
   localparam int ERR_W  = 33;
   localparam int ISUM_W = 48;
   localparam int PSAT_W = 63;
   localparam int U_W    = 64;
   localparam int UC_W   = 33;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int TGT_W      = 24;
   localparam int RATE_W     = 10;
   localparam int LIMIT_W    = 8;
   localparam int DUTY_W     = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_TARGET = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KP     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_KI_DT  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_RATE   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_LIMIT  = 3'd4;

   // Operation codes of an input item
   localparam logic [1:0] OP_EDGE    = 2'd0;
   localparam logic [1:0] OP_SAMPLE  = 2'd1;
   localparam logic [1:0] OP_CONTROL = 2'd2;

   // Command to the shared multiply-accumulate unit
   typedef struct packed {
      logic mul_en;
      logic hi_sel;
      logic acc_load;
      logic acc_add;
   } mul_cmd_type;

endpackage

// ===== rtl/core/espi_mul_unit.sv =====
// Shared multiply-accumulate unit: 24 x 24 partial products over a 48-bit operand.
// Depends on espi_pkg.
module espi_mul_unit (
   input  logic                        clock,
   input  espi_pkg::mul_cmd_type       cmd,
   input  logic [espi_pkg::OPA_W-1:0]  opa,
   input  logic [espi_pkg::GAIN_W-1:0] opb,
   output logic [espi_pkg::ACC_W-1:0]  acc
);
   import espi_pkg::*;

   logic [CHUNK_W-1:0] chunk;
   logic [PROD_W-1:0]  prod_ff;
   logic [ACC_W-1:0]   acc_ff;

   // pick the low or high half of the operand
   assign chunk = cmd.hi_sel ? opa[OPA_W-1:CHUNK_W] : opa[CHUNK_W-1:0];

   // product register, then accumulate with the high half weighted by 2^24
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= chunk * opb;
      end
      if (cmd.acc_load) begin
         acc_ff <= ACC_W'(prod_ff);
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + {prod_ff, {CHUNK_W{1'b0}}};
      end
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/core/espi_div_unit.sv =====
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on espi_pkg.
module espi_div_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [espi_pkg::DVD_W-1:0]  dividend,
   input  logic [espi_pkg::FILL_W-1:0] divisor,
   output logic                        done,
   output logic [espi_pkg::DVD_W-1:0]  quotient
);
   import espi_pkg::*;

   logic [DVD_W-1:0]  work_ff;
   logic [FILL_W-1:0] rem_ff;
   logic [FILL_W-1:0] div_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [FILL_W:0]   trial;
   logic [FILL_W:0]   diff;
   logic              ge;

   // one trial subtraction per step
   assign trial = {rem_ff, work_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   // control: step counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(DVD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: dividend shifts out, quotient bits shift in
   always_ff @(posedge clock) begin
      if (start) begin
         work_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         work_ff <= {work_ff[DVD_W-2:0], ge};
         rem_ff  <= ge ? diff[FILL_W-1:0] : trial[FILL_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

// ===== rtl/core/encoder_speed_pi_controller_core.sv =====
// Encoder speed PI controller, top level. Uses espi_mul_unit, espi_div_unit.
// An edge leaves the sequencer idle. Sample and control ticks occupy it; req_ready
// is low until it is idle, which a control tick reaches as it sends its result.
// Control ticks run the divider (skipped if the window is empty) and two multiplies.
// A waiting result does not block edges or sample ticks.
// Reset is synchronous, active high; it restores the register defaults and clears
// counts, window fill and error sum. Window entries are not reset; an old entry is used only once the window is full.
module encoder_speed_pi_controller_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_operation,
   input  logic                            req_phase_b_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_reverse,
   output logic [espi_pkg::DUTY_W-1:0]     rsp_duty,
   output logic signed [espi_pkg::SPEED_W-1:0] rsp_measured_speed,
   output logic                            rsp_integral_frozen,
   input  logic                            csr_wr_en,
   input  logic [espi_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [espi_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import espi_pkg::*;

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_SPD_ABS = 16'h0002,
      ST_MUL_LO  = 16'h0004,
      ST_MUL_HI  = 16'h0008,
      ST_MUL_ACC = 16'h0010,
      ST_SPD_SAT = 16'h0020,
      ST_SPD_UPD = 16'h0040,
      ST_DIV     = 16'h0080,
      ST_AVG     = 16'h0100,
      ST_ERR     = 16'h0200,
      ST_OPR_KP  = 16'h0400,
      ST_PROD_KP = 16'h0800,
      ST_PROD_KI = 16'h1000,
      ST_SUM_U   = 16'h2000,
      ST_CLAMP   = 16'h4000,
      ST_RESP    = 16'h8000
   } state_type;

   typedef enum logic [1:0] {
      PH_SPEED = 2'd0,
      PH_KP    = 2'd1,
      PH_KI    = 2'd2
   } phase_type;

   localparam logic [ACC_W-1:0] PROD_LIM = ACC_W'(1) << 61;
   localparam logic [ACC_W-1:0] ACC_I32_MAX = ACC_W'(32'h7FFF_FFFF);
   localparam logic [ACC_W-1:0] ACC_I32_NEG = ACC_W'(32'h8000_0000);
   localparam logic [DVD_W-1:0] Q_I32_MAX = DVD_W'(32'h7FFF_FFFF);
   localparam logic [DVD_W-1:0] Q_I32_NEG = DVD_W'(32'h8000_0000);

   state_type state_ff, state_in;
   phase_type phase_ff;

   // configuration registers
   logic signed [TGT_W-1:0] target_ff;
   logic [GAIN_W-1:0]       kp_ff;
   logic [GAIN_W-1:0]       ki_ff;
   logic [RATE_W-1:0]       rate_ff;
   logic [LIMIT_W-1:0]      limit_ff;

   // counting and window state
   logic [COUNT_BITS-1:0]      pos_ff;
   logic [COUNT_BITS-1:0]      prev_ff;
   logic signed [SPEED_W-1:0]  win_mem [WINDOW_LEN];
   logic [IDX_W-1:0]           idx_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [ISUM_W-1:0]   err_sum_ff;

   // working registers
   logic [COUNT_BITS-1:0]      delta_ff;
   logic signed [SPEED_W-1:0]  old_ff;
   logic signed [SPEED_W-1:0]  speed_ff;
   logic [OPA_W-1:0]           mul_a_ff;
   logic [GAIN_W-1:0]          mul_b_ff;
   logic                       neg_ff;
   logic                       sum_neg_ff;
   logic signed [SPEED_W-1:0]  avg_ff;
   logic signed [ERR_W-1:0]    e_ff;
   logic signed [ISUM_W-1:0]   next_ff;
   logic signed [PSAT_W-1:0]   p_kp_ff;
   logic signed [PSAT_W-1:0]   p_ki_ff;
   logic signed [U_W-1:0]      u_ff;
   logic signed [UC_W-1:0]     uc_ff;
   logic                       frozen_ff;
   logic                       rsp_valid_ff;

   logic                       accept;
   logic                       slot_free;
   logic                       div_start;
   logic                       div_done;
   logic [DVD_W-1:0]           div_quot;
   logic [SUM_W-1:0]           sum_abs;
   logic [COUNT_BITS-1:0]      delta_abs;
   mul_cmd_type                mul_cmd;
   logic [ACC_W-1:0]           mul_acc;
   logic [PSAT_W-2:0]          prod_mag;
   logic signed [PSAT_W-1:0]   prod_signed;
   logic signed [SPEED_W-1:0]  speed_sat;
   logic signed [SPEED_W-1:0]  avg_sat;
   logic signed [SPEED_W-1:0]  target_q8;
   logic signed [ISUM_W:0]     isum_wide;
   logic signed [ISUM_W-1:0]   next_sat;
   logic [SPEED_W-1:0]         e_abs;
   logic [ISUM_W-1:0]          next_abs;
   logic signed [U_W-1:0]      lim;
   logic                       e_pos;
   logic                       e_neg;
   logic [SPEED_W-1:0]         uc_abs;
   logic [SPEED_W:0]           duty_sum;

   // handshake
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign div_start = accept && (req_operation == OP_CONTROL) && (fill_ff != '0);

   // magnitudes of signed operands
   assign sum_abs   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign delta_abs = delta_ff[COUNT_BITS-1] ? (~delta_ff + 1'b1) : delta_ff;
   assign e_abs     = e_ff[ERR_W-1] ? SPEED_W'(-e_ff) : SPEED_W'(e_ff);
   assign next_abs  = next_ff[ISUM_W-1] ? ISUM_W'(-next_ff) : ISUM_W'(next_ff);

   // multiply and divide units
   assign mul_cmd.mul_en   = (state_ff == ST_MUL_LO) || (state_ff == ST_MUL_HI);
   assign mul_cmd.hi_sel   = (state_ff == ST_MUL_HI);
   assign mul_cmd.acc_load = (state_ff == ST_MUL_HI);
   assign mul_cmd.acc_add  = (state_ff == ST_MUL_ACC);

   espi_mul_unit u_mul (
      .clock (clock),
      .cmd   (mul_cmd),
      .opa   (mul_a_ff),
      .opb   (mul_b_ff),
      .acc   (mul_acc)
   );

   espi_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({sum_abs, 8'h00}),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // product magnitude capped at 2^61, then signed
   always_comb begin
      prod_mag    = (mul_acc > PROD_LIM) ? PROD_LIM[PSAT_W-2:0] : mul_acc[PSAT_W-2:0];
      prod_signed = neg_ff ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
   end

   // speed saturated to 32 bits
   always_comb begin
      if (neg_ff) begin
         speed_sat = (mul_acc > ACC_I32_NEG) ? $signed(32'h8000_0000)
                                             : $signed(-mul_acc[SPEED_W-1:0]);
      end else begin
         speed_sat = (mul_acc > ACC_I32_MAX) ? $signed(32'h7FFF_FFFF)
                                             : $signed(mul_acc[SPEED_W-1:0]);
      end
   end

   // window average from quotient magnitude, saturated to 32 bits
   always_comb begin
      if (sum_neg_ff) begin
         avg_sat = (div_quot > Q_I32_NEG) ? $signed(32'h8000_0000)
                                          : $signed(-div_quot[SPEED_W-1:0]);
      end else begin
         avg_sat = (div_quot > Q_I32_MAX) ? $signed(32'h7FFF_FFFF)
                                          : $signed(div_quot[SPEED_W-1:0]);
      end
   end

   // error sum candidate, saturated to 48 bits
   always_comb begin
      target_q8 = {target_ff, 8'h00};
      isum_wide = (ISUM_W + 1)'(e_ff) + (ISUM_W + 1)'(err_sum_ff);
      if (isum_wide[ISUM_W] != isum_wide[ISUM_W-1]) begin
         next_sat = isum_wide[ISUM_W] ? $signed({1'b1, {(ISUM_W-1){1'b0}}})
                                      : $signed({1'b0, {(ISUM_W-1){1'b1}}});
      end else begin
         next_sat = isum_wide[ISUM_W-1:0];
      end
   end

   // limit, anti-windup condition and rounded duty
   always_comb begin
      lim      = $signed({{(U_W-LIMIT_W-24){1'b0}}, limit_ff, 24'h000000});
      e_pos    = !e_ff[ERR_W-1] && (e_ff != '0);
      e_neg    = e_ff[ERR_W-1];
      uc_abs   = uc_ff[UC_W-1] ? SPEED_W'(-uc_ff) : SPEED_W'(uc_ff);
      duty_sum = {1'b0, uc_abs} + (SPEED_W + 1)'(33'h0_0080_0000);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  OP_SAMPLE:  state_in = ST_SPD_ABS;
                  OP_CONTROL: state_in = (fill_ff != '0) ? ST_DIV : ST_ERR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SPD_ABS: state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_MUL_ACC;
         ST_MUL_ACC: begin
            case (phase_ff)
               PH_KP:   state_in = ST_PROD_KP;
               PH_KI:   state_in = ST_PROD_KI;
               default: state_in = ST_SPD_SAT;
            endcase
         end
         ST_SPD_SAT: state_in = ST_SPD_UPD;
         ST_SPD_UPD: state_in = ST_IDLE;
         ST_DIV:     state_in = div_done ? ST_AVG : ST_DIV;
         ST_AVG:     state_in = ST_ERR;
         ST_ERR:     state_in = ST_OPR_KP;
         ST_OPR_KP:  state_in = ST_MUL_LO;
         ST_PROD_KP: state_in = ST_MUL_LO;
         ST_PROD_KI: state_in = ST_SUM_U;
         ST_SUM_U:   state_in = ST_CLAMP;
         ST_CLAMP:   state_in = ST_RESP;
         ST_RESP:    state_in = slot_free ? ST_IDLE : ST_RESP;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control state, configuration and persistent counts
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SPEED;
         target_ff    <= TGT_W'(300);
         kp_ff        <= GAIN_W'(2621);
         ki_ff        <= '0;
         rate_ff      <= RATE_W'(100);
         limit_ff     <= LIMIT_W'(255);
         pos_ff       <= '0;
         prev_ff      <= '0;
         idx_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         err_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // configuration writes
         if (csr_wr_en) begin
            case (csr_index)
               REG_TARGET: target_ff <= csr_wr_data[TGT_W-1:0];
               REG_KP:     kp_ff     <= csr_wr_data[GAIN_W-1:0];
               REG_KI_DT:  ki_ff     <= csr_wr_data[GAIN_W-1:0];
               REG_RATE:   rate_ff   <= csr_wr_data[RATE_W-1:0];
               REG_LIMIT:  limit_ff  <= csr_wr_data[LIMIT_W-1:0];
               default:    ;
            endcase
         end

         // encoder edge and snapshot of the count on a sample tick
         if (accept && (req_operation == OP_EDGE)) begin
            pos_ff <= req_phase_b_level ? (pos_ff - 1'b1) : (pos_ff + 1'b1);
         end
         if (accept && (req_operation == OP_SAMPLE)) begin
            prev_ff  <= pos_ff;
            phase_ff <= PH_SPEED;
         end
         if (state_ff == ST_OPR_KP) begin
            phase_ff <= PH_KP;
         end
         if (state_ff == ST_PROD_KP) begin
            phase_ff <= PH_KI;
         end

         // sliding window bookkeeping
         if (state_ff == ST_SPD_UPD) begin
            if (fill_ff < FILL_W'(WINDOW_LEN)) begin
               fill_ff <= fill_ff + 1'b1;
               sum_ff  <= sum_ff + SUM_W'(speed_ff);
            end else begin
               sum_ff  <= sum_ff - SUM_W'(old_ff) + SUM_W'(speed_ff);
            end
            idx_ff <= (idx_ff == IDX_W'(WINDOW_LEN - 1)) ? '0 : idx_ff + 1'b1;
         end

         // result transfer and integral update
         if ((state_ff == ST_RESP) && slot_free) begin
            rsp_valid_ff <= 1'b1;
            if (!frozen_ff) begin
               err_sum_ff <= next_ff;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // window memory: registered read of the oldest entry, write of the new speed
   always_ff @(posedge clock) begin
      if (state_ff == ST_SPD_ABS) begin
         old_ff <= win_mem[idx_ff];
      end
      if (state_ff == ST_SPD_UPD) begin
         win_mem[idx_ff] <= speed_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept && (req_operation == OP_SAMPLE)) begin
         delta_ff <= pos_ff - prev_ff;
      end
      if (accept && (req_operation == OP_CONTROL)) begin
         sum_neg_ff <= sum_ff[SUM_W-1];
         avg_ff     <= '0;
      end
      case (state_ff)
         ST_SPD_ABS: begin
            mul_a_ff <= OPA_W'(delta_abs);
            mul_b_ff <= GAIN_W'(rate_ff);
            neg_ff   <= delta_ff[COUNT_BITS-1];
         end
         ST_SPD_SAT: speed_ff <= speed_sat;
         ST_AVG:     avg_ff   <= avg_sat;
         ST_ERR:     e_ff     <= ERR_W'(target_q8) - ERR_W'(avg_ff);
         ST_OPR_KP: begin
            next_ff  <= next_sat;
            mul_a_ff <= OPA_W'(e_abs);
            mul_b_ff <= kp_ff;
            neg_ff   <= e_ff[ERR_W-1];
         end
         ST_PROD_KP: begin
            p_kp_ff  <= prod_signed;
            mul_a_ff <= next_abs;
            mul_b_ff <= ki_ff;
            neg_ff   <= next_ff[ISUM_W-1];
         end
         ST_PROD_KI: p_ki_ff <= prod_signed;
         ST_SUM_U:   u_ff    <= U_W'(p_kp_ff) + U_W'(p_ki_ff);
         ST_CLAMP: begin
            if (u_ff > lim) begin
               uc_ff <= UC_W'(lim);
            end else if (u_ff < -lim) begin
               uc_ff <= UC_W'(-lim);
            end else begin
               uc_ff <= UC_W'(u_ff);
            end
            // a zero limit pins the command to zero, which sits on both bounds
            frozen_ff <= ((u_ff >= lim) && e_pos) || ((u_ff <= -lim) && e_neg)
                         || ((limit_ff == '0) && (e_pos || e_neg));
         end
         default: ;
      endcase

      // output register
      if ((state_ff == ST_RESP) && slot_free) begin
         rsp_reverse         <= uc_ff[UC_W-1];
         rsp_duty            <= duty_sum[SPEED_W-1:SPEED_W-DUTY_W];
         rsp_measured_speed  <= avg_ff;
         rsp_integral_frozen <= frozen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/espi_checker.sv =====
// Port-level checks for the encoder speed PI controller, bound to the top level.
// Depends on espi_pkg and encoder_speed_pi_controller_core.
module espi_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [1:0]                      req_operation,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_reverse,
   input logic [espi_pkg::DUTY_W-1:0]     rsp_duty,
   input logic signed [espi_pkg::SPEED_W-1:0] rsp_measured_speed,
   input logic                            rsp_integral_frozen
);
   import espi_pkg::*;

   // after reset the block is idle with no pending result
   a_reset_idle: assert property (@(posedge clock) reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

   // an encoder edge completes in the cycle of its transfer
   a_edge_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_EDGE) |=> req_ready)
      else $error("edge transfer held the input channel");

   // a control tick occupies the sequencer
   a_control_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation == OP_CONTROL) |=> !req_ready)
      else $error("control tick did not start the sequencer");

   // a result only appears out of a running control tick
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty)
                                  && $stable(rsp_measured_speed)
                                  && $stable(rsp_reverse)
                                  && $stable(rsp_integral_frozen))
      else $error("stalled result changed");

endmodule

bind encoder_speed_pi_controller_core espi_checker u_espi_checker (.*);
